/* rtl/core/sac_pkg.sv */
package sac_pkg;

	localparam int unsigned AGE_W   = 3;
	localparam int unsigned AGE_MAX = 7;
	localparam int unsigned CFG_W   = 4;
	localparam int unsigned IDX_W   = 3;

	localparam logic [IDX_W-1:0] REG_SET_BITS    = 3'd0;
	localparam logic [IDX_W-1:0] REG_OFFSET_BITS = 3'd1;
	localparam logic [IDX_W-1:0] REG_WAYS        = 3'd2;
	localparam logic [IDX_W-1:0] REG_LRU_MODE    = 3'd3;
	localparam logic [IDX_W-1:0] REG_PREFETCH    = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_NEXT,
		ST_DONE
	} sac_state_t;

	// lookup request from sequencer to set unit
	typedef struct packed {
		logic start;
		logic is_prefetch;
		logic lru;
	} sac_req_t;

	// lookup outcome back to the sequencer
	typedef struct packed {
		logic done;
		logic found;
	} sac_rsp_t;

endpackage

/* rtl/core/sac_if.sv */
interface sac_if #(
	parameter int unsigned W = 1
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/sac_set_unit.sv */
module sac_set_unit
	import sac_pkg::*;
#(
	parameter int unsigned SETS   = 256,
	parameter int unsigned WAYS   = 8,
	parameter int unsigned TAG_W  = 48
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sac_req_t                  req,
	input  logic [$clog2(SETS)-1:0]   set_idx,
	input  logic [TAG_W-1:0]          tag,
	input  logic [$clog2(WAYS+1)-1:0] ways,
	output sac_rsp_t                  rsp
);

	localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned WN_W  = $clog2(WAYS+1);

	// one row per set holds every way
	typedef struct packed {
		logic [WAYS-1:0]             vld;
		logic [WAYS-1:0][AGE_W-1:0]  age;
		logic [WAYS-1:0][TAG_W-1:0]  tg;
	} row_t;

	row_t                 mem [SETS];
	row_t                 rd_s1;
	logic [SETS-1:0]      row_ok_q;
	logic                 busy_s1;
	logic                 pf_s1;
	logic                 lru_s1;
	logic [SET_W-1:0]     set_s1;
	logic [TAG_W-1:0]     tag_s1;
	logic [WN_W-1:0]      ways_s1;
	logic                 ok_s1;

	row_t                 row_in;
	row_t                 row_new;
	logic [WAYS-1:0]      in_use;
	logic [WAYS-1:0]      match;
	logic                 found;
	logic [WAY_W-1:0]     hit_w;
	logic [WAY_W-1:0]     vic_w;
	logic                 any_free;
	logic [AGE_W-1:0]     best;
	logic                 wr_en;

	logic [SET_W-1:0] set_w;
	assign set_w = SET_W'(set_idx);

	always_ff @(posedge clk) begin
		if (req.start) begin
			rd_s1 <= mem[set_w];
		end
		if (wr_en) begin
			mem[set_s1] <= row_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q <= '0;
			busy_s1  <= 1'b0;
			ok_s1    <= 1'b0;
		end else begin
			busy_s1 <= req.start;
			if (req.start) begin
				ok_s1 <= row_ok_q[set_w];
			end
			if (wr_en) begin
				row_ok_q[set_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			pf_s1   <= req.is_prefetch;
			lru_s1  <= req.lru;
			set_s1  <= set_w;
			tag_s1  <= tag;
			ways_s1 <= ways;
		end
	end

	always_comb begin
		row_in = rd_s1;
		if (!ok_s1) begin
			row_in.vld = '0;
			row_in.age = '0;
		end
		for (int w = 0; w < WAYS; w++) begin
			in_use[w] = (WN_W'(w) < ways_s1);
			match[w]  = in_use[w] && row_in.vld[w] && (row_in.tg[w] == tag_s1);
		end
		found = 1'b0;
		hit_w = '0;
		for (int w = WAYS-1; w >= 0; w--) begin
			if (match[w]) begin
				found = 1'b1;
				hit_w = WAY_W'(w);
			end
		end
		any_free = 1'b0;
		vic_w    = '0;
		for (int w = WAYS-1; w >= 0; w--) begin
			if (in_use[w] && !row_in.vld[w]) begin
				any_free = 1'b1;
				vic_w    = WAY_W'(w);
			end
		end
		if (!any_free) begin
			best = row_in.age[0];
			for (int w = 1; w < WAYS; w++) begin
				if (in_use[w] && row_in.age[w] > best) begin
					best  = row_in.age[w];
					vic_w = WAY_W'(w);
				end
			end
		end else begin
			best = '0;
		end
		row_new = row_in;
		wr_en   = 1'b0;
		if (busy_s1) begin
			if (!found) begin
				wr_en = 1'b1;
				for (int w = 0; w < WAYS; w++) begin
					if (WAY_W'(w) != vic_w && in_use[w] && row_in.vld[w]
						&& row_in.age[w] != AGE_W'(AGE_MAX)) begin
						row_new.age[w] = row_in.age[w] + AGE_W'(1);
					end
				end
				row_new.vld[vic_w] = 1'b1;
				row_new.tg[vic_w]  = tag_s1;
				row_new.age[vic_w] = '0;
			end else if (!pf_s1 && lru_s1) begin
				wr_en = 1'b1;
				for (int w = 0; w < WAYS; w++) begin
					if (WAY_W'(w) != hit_w && in_use[w] && row_in.vld[w]
						&& row_in.age[w] < row_in.age[hit_w]) begin
						row_new.age[w] = row_in.age[w] + AGE_W'(1);
					end
				end
				row_new.age[hit_w] = '0;
			end
		end
	end

	assign rsp.done  = busy_s1;
	assign rsp.found = found;

endmodule

/* rtl/core/set_assoc_cache_with_prefetch.sv */
// set-associative cache model with next-line prefetch, write-through,
// write-allocate
//
// channels: access_in (sink) carries {opcode, address}; result_out (source)
// carries {hit, memory_reads, memory_write}; one result word per access word
// config: cfg_we / cfg_index / cfg_data write one register per cycle; the user
// must write only while the block is idle, the block itself does not enforce it
//
// each lookup in the set unit reads the set row into a register, then
// updates the row and writes it back; the ST_NEXT state then steps to the
// following address. a hit ends after its own lookup; a miss is followed by
// one prefetch lookup per configured prefetch, up to MAX_PREFETCH, and the
// next access is taken once the block is back in the idle state.
// one access is handled at a time: the set row memory and its
// read-modify-write allow no overlap
//
// reset clears the control registers and the per-set row valid bits at once, so
// every line reads invalid with age zero; no clearing pass is needed
// a stalled result stays in the output register; one more access may be
// taken and looked up meanwhile, and its result then waits in the done
// state until the register is free, which holds off further input
module set_assoc_cache_with_prefetch
	import sac_pkg::*;
#(
	parameter int unsigned MAX_SETS     = 256,
	parameter int unsigned MAX_WAYS     = 8,
	parameter int unsigned MAX_PREFETCH = 8,
	parameter int unsigned ADDR_BITS    = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	sac_if.sink                  access_in,
	sac_if.source                result_out
);

	localparam int unsigned SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int unsigned SB_MAX = $clog2(MAX_SETS + 1) - 1;
	localparam int unsigned WN_W  = $clog2(MAX_WAYS + 1);
	localparam int unsigned PF_W  = $clog2(MAX_PREFETCH + 1) + 1;

	// registers
	logic [CFG_W-1:0] set_bits_q, offset_bits_q, ways_q, pf_q;
	logic             lru_q;

	sac_state_t           state_q, state_d;
	logic                 wr_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [PF_W-1:0]      left_q;
	logic [3:0]           reads_q;
	logic                 hit_q;
	logic                 first_q;
	logic                 out_vld_q;
	logic [5:0]           out_q;

	logic [3:0]           sb_eff;
	logic [WN_W-1:0]      ways_eff;
	logic [PF_W-1:0]      pf_eff;
	logic [ADDR_BITS-1:0] shifted;
	logic [SET_W-1:0]     set_idx;
	logic [ADDR_BITS-1:0] tag;
	sac_req_t             req;
	sac_rsp_t             rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= '0;
			offset_bits_q <= '0;
			ways_q        <= CFG_W'(1);
			lru_q         <= 1'b0;
			pf_q          <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SET_BITS:    set_bits_q    <= cfg_data;
				REG_OFFSET_BITS: offset_bits_q <= cfg_data;
				REG_WAYS:        ways_q        <= cfg_data;
				REG_LRU_MODE:    lru_q         <= cfg_data[0];
				REG_PREFETCH:    pf_q          <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturate the geometry and the prefetch count; zero ways reads as one
	assign sb_eff   = (32'(set_bits_q) > SB_MAX) ? 4'(SB_MAX) : set_bits_q;
	assign ways_eff = (ways_q == '0) ? WN_W'(1)
		: ((32'(ways_q) > MAX_WAYS) ? WN_W'(MAX_WAYS) : WN_W'(ways_q));
	assign pf_eff   = (32'(pf_q) > MAX_PREFETCH) ? PF_W'(MAX_PREFETCH) : PF_W'(pf_q);

	// address split
	assign shifted = addr_q >> offset_bits_q;
	assign set_idx = SET_W'(shifted & ((ADDR_BITS'(1) << sb_eff) - ADDR_BITS'(1)));
	assign tag     = shifted >> sb_eff;

	sac_set_unit #(
		.SETS  (MAX_SETS),
		.WAYS  (MAX_WAYS),
		.TAG_W (ADDR_BITS)
	) u_set (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.set_idx (set_idx),
		.tag     (tag),
		.ways    (ways_eff),
		.rsp     (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		req.start       = 1'b0;
		req.is_prefetch = !first_q;
		req.lru         = lru_q;
		unique case (state_q)
			ST_IDLE: begin
				if (access_in.valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				req.start = 1'b1;
				state_d   = ST_UPDATE;
			end
			ST_UPDATE: begin
				// left_q still counts the prefetch now being looked up
				if (rsp.done) begin
					if ((first_q && rsp.found) || (!first_q && left_q == PF_W'(1))
						|| (first_q && pf_eff == '0)) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_NEXT;
					end
				end
			end
			ST_NEXT: begin
				state_d = ST_READ;
			end
			ST_DONE: begin
				if (!out_vld_q || result_out.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign access_in.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			first_q   <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!out_vld_q || result_out.ready)) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && result_out.ready) begin
				out_vld_q <= 1'b0;
			end
			if (access_in.valid && access_in.ready) begin
				first_q <= 1'b1;
			end else if (state_q == ST_UPDATE && rsp.done) begin
				first_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (access_in.valid && access_in.ready) begin
			wr_q    <= access_in.data[ADDR_BITS];
			addr_q  <= access_in.data[ADDR_BITS-1:0];
			reads_q <= '0;
			hit_q   <= 1'b0;
			left_q  <= pf_eff;
		end
		if (state_q == ST_UPDATE && rsp.done) begin
			if (first_q) begin
				hit_q <= rsp.found;
			end else begin
				left_q <= left_q - PF_W'(1);
			end
			if (!rsp.found) begin
				reads_q <= reads_q + 4'd1;
			end
		end
		if (state_q == ST_NEXT) begin
			addr_q <= addr_q + (ADDR_BITS'(1) << offset_bits_q);
			if (first_q) begin
				left_q <= left_q;
			end
		end
		if (state_q == ST_DONE && (!out_vld_q || result_out.ready)) begin
			out_q <= {hit_q, reads_q, wr_q};
		end
	end

	assign result_out.valid = out_vld_q;
	assign result_out.data  = out_q;

	// a result word is never made while one waits unsent
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !result_out.ready |=> $stable(out_q))
		else $error("pending result changed");

	// a hit never reports memory reads
	a_hit_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid |-> !(out_q[5] && out_q[4:1] != 4'd0))
		else $error("hit with reads");

	// no access accepted while a lookup runs
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> !access_in.ready)
		else $error("accept during lookup");

endmodule
